/* hw/rtl/ubu_pkg.sv */
// Shared types and constants for the UART boot image upload host.
package ubu_pkg;

    localparam int unsigned SIZE_W  = 16;
    localparam int unsigned LIMIT_W = 8;
    localparam int unsigned MAX_RES = 3;

    localparam logic [7:0] SYM_SOH  = 8'h01;
    localparam logic [7:0] SYM_STX  = 8'h02;
    localparam logic [7:0] SYM_ACK  = 8'h06;
    localparam logic [7:0] SYM_NACK = 8'h15;
    localparam logic [7:0] XOR_INIT = 8'h00;

    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_RX    = 2'd1;
    localparam logic [1:0] KIND_IMAGE = 2'd2;

    localparam logic OUT_TX     = 1'b0;
    localparam logic OUT_FINISH = 1'b1;

    localparam logic OUTCOME_OK   = 1'b0;
    localparam logic OUTCOME_FAIL = 1'b1;

    localparam logic CFG_IMAGE_SIZE    = 1'b0;
    localparam logic CFG_ATTEMPT_LIMIT = 1'b1;

    localparam logic [SIZE_W-1:0]  IMAGE_SIZE_RST    = 16'd0;
    localparam logic [LIMIT_W-1:0] ATTEMPT_LIMIT_RST = 8'd10;

    typedef struct packed {
        logic       out_kind;
        logic [7:0] out_byte;
        logic       outcome;
        logic       last;
    } t_result;

    typedef t_result [MAX_RES-1:0] t_bundle;

    localparam t_result RES_NONE = '{out_kind: OUT_TX, out_byte: 8'h00,
                                     outcome: OUTCOME_OK, last: 1'b0};
    localparam t_result RES_FAIL = '{out_kind: OUT_FINISH, out_byte: 8'h00,
                                     outcome: OUTCOME_FAIL, last: 1'b1};

endpackage

/* hw/rtl/ubu_core.sv */
// Upload sequencer: phase, retry count, byte count and checksum, plus result bundle.
module ubu_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_take,
    input  logic [1:0]                   i_kind,
    input  logic [7:0]                   i_data,
    input  logic [ubu_pkg::SIZE_W-1:0]   i_image_size,
    input  logic [ubu_pkg::LIMIT_W-1:0]  i_attempt_limit,
    output ubu_pkg::t_bundle             o_res,
    output logic [1:0]                   o_num
);
    import ubu_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_W4STX,
        PH_W4ACK,
        PH_IMAGE,
        PH_W4SUM
    } t_phase;

    t_phase              r_phase, n_phase;
    logic [LIMIT_W-1:0]  r_attempts, n_attempts;
    logic [SIZE_W-1:0]   r_bytes_sent, n_bytes_sent;
    logic [7:0]          r_xor, n_xor;

    logic [LIMIT_W-1:0]  att_inc;
    logic [SIZE_W-1:0]   bs_inc;
    logic [7:0]          xor_upd;

    assign att_inc = (r_attempts == {LIMIT_W{1'b1}}) ? r_attempts
                                                     : r_attempts + LIMIT_W'(1);
    assign bs_inc  = r_bytes_sent + SIZE_W'(1);
    assign xor_upd = r_xor ^ i_data;

    always_comb begin
        n_phase      = r_phase;
        n_attempts   = r_attempts;
        n_bytes_sent = r_bytes_sent;
        n_xor        = r_xor;
        o_res        = {MAX_RES{RES_NONE}};
        o_num        = 2'd0;
        case (i_kind)
            KIND_START: begin
                n_attempts   = '0;
                n_bytes_sent = '0;
                n_xor        = XOR_INIT;
                n_phase      = PH_W4STX;
            end
            KIND_RX: begin
                case (r_phase)
                    PH_W4STX: begin
                        if (i_data == SYM_STX) begin
                            o_res[0] = '{out_kind: OUT_TX, out_byte: SYM_SOH,
                                         outcome: OUTCOME_OK, last: 1'b0};
                            o_res[1] = '{out_kind: OUT_TX, out_byte: i_image_size[7:0],
                                         outcome: OUTCOME_OK, last: 1'b0};
                            o_res[2] = '{out_kind: OUT_TX, out_byte: i_image_size[15:8],
                                         outcome: OUTCOME_OK, last: 1'b1};
                            o_num    = 2'd3;
                            n_phase  = PH_W4ACK;
                        end
                    end
                    PH_W4ACK: begin
                        if (i_data == SYM_ACK) begin
                            n_bytes_sent = '0;
                            n_xor        = XOR_INIT;
                            n_phase      = (i_image_size == '0) ? PH_W4SUM : PH_IMAGE;
                        end else if (i_data == SYM_NACK) begin
                            n_phase  = PH_IDLE;
                            o_res[0] = RES_FAIL;
                            o_num    = 2'd1;
                        end else begin
                            n_attempts = att_inc;
                            if (att_inc < i_attempt_limit) begin
                                n_phase = PH_W4STX;
                            end else begin
                                n_phase  = PH_IDLE;
                                o_res[0] = RES_FAIL;
                                o_num    = 2'd1;
                            end
                        end
                    end
                    PH_W4SUM: begin
                        n_phase = PH_IDLE;
                        if (i_data == r_xor) begin
                            o_res[0] = '{out_kind: OUT_TX, out_byte: SYM_ACK,
                                         outcome: OUTCOME_OK, last: 1'b0};
                            o_res[1] = '{out_kind: OUT_FINISH, out_byte: 8'h00,
                                         outcome: OUTCOME_OK, last: 1'b1};
                            o_num    = 2'd2;
                        end else begin
                            o_res[0] = RES_FAIL;
                            o_num    = 2'd1;
                        end
                    end
                    default: ;
                endcase
            end
            KIND_IMAGE: begin
                if (r_phase == PH_IMAGE) begin
                    n_xor        = xor_upd;
                    n_bytes_sent = bs_inc;
                    if (bs_inc >= i_image_size) begin
                        n_phase = PH_W4SUM;
                    end
                    o_res[0] = '{out_kind: OUT_TX, out_byte: i_data,
                                 outcome: OUTCOME_OK, last: 1'b1};
                    o_num    = 2'd1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_attempts   <= '0;
            r_bytes_sent <= '0;
            r_xor        <= XOR_INIT;
        end else if (i_take) begin
            r_phase      <= n_phase;
            r_attempts   <= n_attempts;
            r_bytes_sent <= n_bytes_sent;
            r_xor        <= n_xor;
        end
    end

endmodule

/* hw/rtl/ubu_out_buf.sv */
// Result register: holds one item's results and hands them out one per transaction.
module ubu_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  ubu_pkg::t_bundle  i_res,
    input  logic [1:0]        i_num,
    output logic              o_free,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output ubu_pkg::t_result  o_res
);
    import ubu_pkg::*;

    t_bundle    r_res;
    logic [1:0] r_num;
    logic       deliver;

    assign o_out_valid = (r_num != 2'd0);
    assign deliver     = o_out_valid && i_out_ready;
    assign o_free      = (r_num == 2'd0) || ((r_num == 2'd1) && i_out_ready);
    assign o_res       = r_res[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num <= 2'd0;
        end else if (i_load) begin
            r_num <= i_num;
        end else if (deliver) begin
            r_num <= r_num - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end else if (deliver) begin
            r_res[0] <= r_res[1];
            r_res[1] <= r_res[2];
        end
    end

endmodule

/* hw/rtl/uart_boot_image_upload_host_unit.sv */
// Top level of the UART boot image upload host.
//
// Input channel (i_in_valid/o_in_ready, i_kind, i_data): start, byte received
// from the target, or image byte to send. Result channel (o_out_valid/
// i_out_ready): bytes to transmit and the finish report, o_last marking the
// final result of an item. Items that cause no result produce nothing.
// Configuration channel (i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data) is
// always ready; write it only while the block is idle.
// An item waits in the input register; once taken, its decoded results load
// into the result register. An item is accepted every cycle while the result
// register is empty or delivering its final result; an item with n results
// holds the result channel for n transactions (n at most 3).
// A stalled receiver holds the result register, then the input register, and
// o_in_ready drops. Synchronous reset clears the phase, counters, checksum,
// both registers' valid state and the configuration (size 0, limit 10).
module uart_boot_image_upload_host_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_kind,
    input  logic [7:0]                   i_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_out_kind,
    output logic [7:0]                   o_out_byte,
    output logic                         o_outcome,
    output logic                         o_last,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic                         i_cfg_index,
    input  logic [ubu_pkg::SIZE_W-1:0]   i_cfg_data
);
    import ubu_pkg::*;

    logic               r_in_vld;
    logic [1:0]         r_kind;
    logic [7:0]         r_data;
    logic [SIZE_W-1:0]  r_image_size;
    logic [LIMIT_W-1:0] r_attempt_limit;

    logic       buf_free;
    logic       take;
    t_bundle    core_res;
    logic [1:0] core_num;
    t_result    out_res;

    assign take        = r_in_vld && buf_free;
    assign o_in_ready  = !r_in_vld || buf_free;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_vld <= 1'b1;
        end else if (take) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_kind <= i_kind;
            r_data <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_size    <= IMAGE_SIZE_RST;
            r_attempt_limit <= ATTEMPT_LIMIT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IMAGE_SIZE:    r_image_size    <= i_cfg_data;
                CFG_ATTEMPT_LIMIT: r_attempt_limit <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    ubu_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_take         (take),
        .i_kind         (r_kind),
        .i_data         (r_data),
        .i_image_size   (r_image_size),
        .i_attempt_limit(r_attempt_limit),
        .o_res          (core_res),
        .o_num          (core_num)
    );

    ubu_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (take),
        .i_res      (core_res),
        .i_num      (core_num),
        .o_free     (buf_free),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_res      (out_res)
    );

    assign o_out_kind = out_res.out_kind;
    assign o_out_byte = out_res.out_byte;
    assign o_outcome  = out_res.outcome;
    assign o_last     = out_res.last;

endmodule

/* hw/rtl/ubu_chk.sv */
// Port-level checks for the upload host, bound to the top level.
module ubu_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_out_kind,
    input logic [7:0] o_out_byte,
    input logic       o_outcome,
    input logic       o_last
);
    import ubu_pkg::*;

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result valid dropped before its transaction");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_finish_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_kind == OUT_FINISH) |-> o_last && (o_out_byte == 8'h00))
        else $error("finish report not last or carries a byte");

    a_tx_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_kind == OUT_TX) |-> (o_outcome == OUTCOME_OK))
        else $error("transmit result carries a failure outcome");

endmodule

bind uart_boot_image_upload_host_unit ubu_chk u_ubu_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out_kind (o_out_kind),
    .o_out_byte (o_out_byte),
    .o_outcome  (o_outcome),
    .o_last     (o_last)
);
